[rtl/lrect_pkg.sv]
// ============================================================================
// lrect_pkg
// Shared types and codes for the layered rectangle overlap index.
// ============================================================================
`default_nettype none

package lrect_pkg;

    // operation codes carried in the input word
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_INSERTED = 3'd0;
    localparam logic [2:0] KIND_REJECTED = 3'd1;
    localparam logic [2:0] KIND_MATCH    = 3'd2;
    localparam logic [2:0] KIND_NO_MATCH = 3'd3;
    localparam logic [2:0] KIND_CLEARED  = 3'd4;

    // most results one query may produce
    localparam int RESULT_CAP = 32;

    // width of the layer-limit register
    localparam int CFG_W = 4;

    typedef struct packed {
        logic signed [31:0] x_min;
        logic signed [31:0] y_min;
        logic signed [31:0] x_max;
        logic signed [31:0] y_max;
    } box_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         layer;
        logic signed [31:0] box_x_min;
        logic signed [31:0] box_y_min;
        logic signed [31:0] box_x_max;
        logic signed [31:0] box_y_max;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [4:0]         found_slot;
        logic signed [31:0] found_x_min;
        logic signed [31:0] found_y_min;
        logic signed [31:0] found_x_max;
        logic signed [31:0] found_y_max;
        logic [5:0]         layer_count;
        logic [5:0]         peak_count;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture the accepted input word
        logic cfg_wr;      // write the layer limit, empty all buckets
        logic single;      // execute insert/clear/other and load its result
        logic scan_init;   // reset the scan engine
        logic scan_step;   // scan engine may advance
        logic finish;      // load the final query result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic out_free;
        logic scan_done;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/lrect_ctrl.sv]
// ============================================================================
// lrect_ctrl
// Sequencer: accepts a word, dispatches it, runs the query scan to its end.
// ============================================================================
`default_nettype none

module lrect_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire lrect_pkg::dp_status_t status,
    output lrect_pkg::ctrl_cmd_t       cmd
);

    lrect_pkg::ctrl_state_t state_reg;
    lrect_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrect_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrect_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    state_next = lrect_pkg::ST_DECODE;
                end
            end
            lrect_pkg::ST_DECODE:
            begin
                if (status.is_query)
                begin
                    state_next = lrect_pkg::ST_SCAN;
                end
                else if (status.out_free)
                begin
                    state_next = lrect_pkg::ST_IDLE;
                end
            end
            lrect_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = lrect_pkg::ST_FINISH;
                end
            end
            lrect_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = lrect_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrect_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs; a config write takes the idle cycle ahead of any input word
    always_comb
    begin
        in_stall      = (state_reg != lrect_pkg::ST_IDLE) || cfg_valid;
        cfg_ready     = (state_reg == lrect_pkg::ST_IDLE);
        cmd           = '0;
        cmd.load_item = in_valid && !in_stall;
        cmd.cfg_wr    = cfg_valid && cfg_ready;
        case (state_reg)
            lrect_pkg::ST_DECODE:
            begin
                cmd.scan_init = status.is_query;
                cmd.single    = !status.is_query && status.out_free;
            end
            lrect_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            lrect_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd.single = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/lrect_dp.sv]
// ============================================================================
// lrect_dp
// Datapath: box memory, bucket counts, scan engine and output register.
// ============================================================================
`default_nettype none

module lrect_dp #(
    parameter int MAX_LAYERS   = 8,
    parameter int BUCKET_DEPTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lrect_pkg::ctrl_cmd_t           cmd,
    output lrect_pkg::dp_status_t               status,
    input  wire lrect_pkg::in_item_t            in_data,
    input  wire logic [lrect_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output lrect_pkg::out_item_t                out_data
);

    localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CW    = $clog2(BUCKET_DEPTH + 1);
    localparam int DEPTH = MAX_LAYERS * BUCKET_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CW-1:0] BD_CNT   = CW'(BUCKET_DEPTH);
    localparam logic [4:0]    NL_MAX   = 5'(MAX_LAYERS);
    localparam logic [lrect_pkg::CFG_W-1:0] NL_RESET =
        lrect_pkg::CFG_W'((MAX_LAYERS < 8) ? MAX_LAYERS : 8);
    localparam logic [5:0]    CAP_CNT  = 6'(lrect_pkg::RESULT_CAP);

    function automatic logic [AW-1:0] box_addr(input logic [LW-1:0] lay,
                                               input logic [SW-1:0] slot);
        return AW'(AW'(lay) * AW'(BUCKET_DEPTH)) + AW'(slot);
    endfunction

    // closed extents: a shared edge overlaps
    function automatic logic overlaps(input lrect_pkg::box_t f,
                                      input lrect_pkg::box_t q);
        return !((f.x_max < q.x_min) || (f.x_min > q.x_max) ||
                 (f.y_max < q.y_min) || (f.y_min > q.y_max));
    endfunction

    function automatic lrect_pkg::out_item_t make_res(
        input logic [2:0]      kind,
        input logic [4:0]      slot,
        input lrect_pkg::box_t b,
        input logic [5:0]      lc,
        input logic [5:0]      pk,
        input logic            last
    );
        lrect_pkg::out_item_t r;
        r.kind        = kind;
        r.found_slot  = slot;
        r.found_x_min = b.x_min;
        r.found_y_min = b.y_min;
        r.found_x_max = b.x_max;
        r.found_y_max = b.y_max;
        r.layer_count = lc;
        r.peak_count  = pk;
        r.last        = last;
        return r;
    endfunction

    // ---------------------------------------------------------------- state
    lrect_pkg::in_item_t            item_reg;
    logic [lrect_pkg::CFG_W-1:0]    nl_reg, nl_next;
    logic [CW-1:0]                  counts_reg [MAX_LAYERS];
    logic [CW-1:0]                  counts_next [MAX_LAYERS];
    logic [CW-1:0]                  peak_reg, peak_next;

    lrect_pkg::box_t                box_mem [DEPTH];
    lrect_pkg::box_t                rd_data_reg;

    logic [CW-1:0]                  scan_idx_reg, scan_idx_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0]                  cmp_idx_reg;
    logic                           pend_vld_reg, pend_vld_next;
    lrect_pkg::box_t                pend_box_reg;
    logic [SW-1:0]                  pend_slot_reg;
    logic [5:0]                     match_cnt_reg, match_cnt_next;

    logic                           out_vld_reg, out_vld_next;
    lrect_pkg::out_item_t           out_data_reg, out_data_next;

    // ---------------------------------------------------------------- decode
    lrect_pkg::box_t                q_box;
    logic [LW-1:0]                  lidx;
    logic                           lay_ok;
    logic [CW-1:0]                  cur_cnt;
    logic                           ins_ok;
    logic [CW-1:0]                  new_cnt;
    logic [CW-1:0]                  new_peak;
    logic                           is_insert;
    logic                           is_clear;
    logic [lrect_pkg::CFG_W-1:0]    cfg_clamped;
    lrect_pkg::out_item_t           single_res;

    assign q_box.x_min = item_reg.box_x_min;
    assign q_box.y_min = item_reg.box_y_min;
    assign q_box.x_max = item_reg.box_x_max;
    assign q_box.y_max = item_reg.box_y_max;

    assign lidx      = item_reg.layer[LW-1:0];
    assign lay_ok    = item_reg.layer < nl_reg;
    assign cur_cnt   = lay_ok ? counts_reg[lidx] : '0;
    assign ins_ok    = lay_ok && (cur_cnt < BD_CNT);
    assign new_cnt   = cur_cnt + 1'b1;
    assign new_peak  = (new_cnt > peak_reg) ? new_cnt : peak_reg;
    assign is_insert = item_reg.func == lrect_pkg::FUNC_INSERT;
    assign is_clear  = item_reg.func == lrect_pkg::FUNC_CLEAR;

    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped = lrect_pkg::CFG_W'(1);
        end
        else if ({1'b0, cfg_data} > NL_MAX)
        begin
            cfg_clamped = lrect_pkg::CFG_W'(MAX_LAYERS);
        end
    end

    // one-result operations
    always_comb
    begin
        case (item_reg.func)
            lrect_pkg::FUNC_INSERT:
            begin
                if (ins_ok)
                begin
                    single_res = make_res(lrect_pkg::KIND_INSERTED, 5'(cur_cnt), '0,
                                          6'(new_cnt), 6'(new_peak), 1'b1);
                end
                else
                begin
                    single_res = make_res(lrect_pkg::KIND_REJECTED, 5'd0, '0,
                                          6'(cur_cnt), 6'(peak_reg), 1'b1);
                end
            end
            lrect_pkg::FUNC_CLEAR:
            begin
                single_res = make_res(lrect_pkg::KIND_CLEARED, 5'd0, '0,
                                      6'd0, 6'd0, 1'b1);
            end
            default:
            begin
                single_res = make_res(lrect_pkg::KIND_REJECTED, 5'd0, '0,
                                      6'(cur_cnt), 6'(peak_reg), 1'b1);
            end
        endcase
    end

    // ---------------------------------------------------------------- counts
    always_comb
    begin
        nl_next     = nl_reg;
        peak_next   = peak_reg;
        counts_next = counts_reg;
        if (cmd.cfg_wr)
        begin
            nl_next   = cfg_clamped;
            peak_next = '0;
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                counts_next[i] = '0;
            end
        end
        else if (cmd.single && is_clear)
        begin
            peak_next = '0;
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                counts_next[i] = '0;
            end
        end
        else if (cmd.single && is_insert && ins_ok)
        begin
            counts_next[lidx] = new_cnt;
            peak_next         = new_peak;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg   <= NL_RESET;
            peak_reg <= '0;
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            nl_reg     <= nl_next;
            peak_reg   <= peak_next;
            counts_reg <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
    end

    // ---------------------------------------------------------------- memory
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    assign wr_en   = cmd.single && is_insert && ins_ok;
    assign wr_addr = box_addr(lidx, cur_cnt[SW-1:0]);
    assign rd_addr = box_addr(lidx, scan_idx_reg[SW-1:0]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_mem[wr_addr] <= q_box;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= box_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- scan
    // read slot k while slot k-1 is compared; a hit is parked in the pending
    // slot until the next hit or the end of the scan tells whether it is last
    logic                   out_free;
    logic                   scan_done;
    logic                   hit;
    logic                   consume;
    logic                   issue;
    logic                   flush_pend;
    lrect_pkg::out_item_t   pend_res;

    assign out_free   = !out_vld_reg || !out_stall;
    assign scan_done  = (match_cnt_reg == CAP_CNT) ||
                        (!cmp_vld_reg && (scan_idx_reg >= cur_cnt));
    assign hit        = cmp_vld_reg && overlaps(rd_data_reg, q_box);
    assign consume    = cmd.scan_step && !scan_done &&
                        !(hit && pend_vld_reg && !out_free);
    assign issue      = scan_idx_reg < cur_cnt;
    assign rd_en      = consume && issue;
    assign flush_pend = consume && hit && pend_vld_reg;
    assign pend_res   = make_res(lrect_pkg::KIND_MATCH, 5'(pend_slot_reg), pend_box_reg,
                                 6'(cur_cnt), 6'(peak_reg), cmd.finish);

    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        pend_vld_next  = pend_vld_reg;
        match_cnt_next = match_cnt_reg;
        if (cmd.scan_init)
        begin
            scan_idx_next  = '0;
            cmp_vld_next   = 1'b0;
            pend_vld_next  = 1'b0;
            match_cnt_next = '0;
        end
        else if (consume)
        begin
            cmp_vld_next = issue;
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            if (hit)
            begin
                pend_vld_next  = 1'b1;
                match_cnt_next = match_cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            match_cnt_reg <= '0;
        end
        else
        begin
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            pend_vld_reg  <= pend_vld_next;
            match_cnt_reg <= match_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cmp_idx_reg <= scan_idx_reg[SW-1:0];
        end
        if (consume && hit)
        begin
            pend_box_reg  <= rd_data_reg;
            pend_slot_reg <= cmp_idx_reg;
        end
    end

    // ---------------------------------------------------------------- output
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        if (cmd.single)
        begin
            out_vld_next  = 1'b1;
            out_data_next = single_res;
        end
        else if (cmd.finish)
        begin
            out_vld_next = 1'b1;
            if (pend_vld_reg)
            begin
                out_data_next = pend_res;
            end
            else
            begin
                out_data_next = make_res(lrect_pkg::KIND_NO_MATCH, 5'd0, '0,
                                         6'(cur_cnt), 6'(peak_reg), 1'b1);
            end
        end
        else if (flush_pend)
        begin
            out_vld_next  = 1'b1;
            out_data_next = pend_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid        = out_vld_reg;
    assign out_data         = out_data_reg;
    assign status.is_query  = item_reg.func == lrect_pkg::FUNC_QUERY;
    assign status.out_free  = out_free;
    assign status.scan_done = scan_done;

endmodule

`default_nettype wire

[rtl/layered_rect_overlap_index_core.sv]
// ============================================================================
// layered_rect_overlap_index_core
// Per-layer rectangle buckets with insert, closed-overlap query and clear.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall/in_data): one word per operation:
//   insert, query or clear. Output channel (out_valid/out_stall/out_data):
//   one word per result; the final result of an operation has last set.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the layer limit and
//   empties every bucket; write it only while the block is idle.
// Timing (no sink stall):
//   One operation at a time. Insert, clear and bad codes: the word is
//   decoded in DECODE, which loads its result into the output register and
//   returns to idle, where the next word can be taken.
//   Query: DECODE starts the scan, SCAN compares the stored boxes (none for
//   an empty bucket or a bad layer), one per cycle, paced by the single read
//   port of the box memory, and FINISH loads the final result. The next word
//   is taken in the idle state that follows.
// Reset: buckets empty, peak zero, layer limit = min(MAX_LAYERS, 8); the
//   box memory has no clearing pass and is ready at once.
// Stall: a result waits in the output register while out_stall is high;
//   the scan holds only when a second match needs that register.
// ============================================================================
`default_nettype none

module layered_rect_overlap_index_core #(
    parameter int MAX_LAYERS   = 8,
    parameter int BUCKET_DEPTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire lrect_pkg::in_item_t         in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output lrect_pkg::out_item_t             out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lrect_pkg::CFG_W-1:0] cfg_data
);

    lrect_pkg::ctrl_cmd_t  cmd;
    lrect_pkg::dp_status_t status;

    // sequencer
    lrect_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage, compare and result words
    lrect_dp #(
        .MAX_LAYERS   (MAX_LAYERS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[rtl/lrect_chk.sv]
// ============================================================================
// lrect_chk
// Port-level checks for the overlap index, bound to the top level.
// ============================================================================
`default_nettype none

module lrect_chk (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire lrect_pkg::out_item_t        out_data,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");

    // one operation at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !cfg_ready)
        else $error("second word taken while busy");

    // config write wins the idle cycle
    a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> in_stall)
        else $error("input taken together with config write");

    // only a match can be followed by more results
    a_not_last_is_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.kind == lrect_pkg::KIND_MATCH)
        else $error("non-final result that is not a match");

    // nothing shown straight out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind layered_rect_overlap_index_core lrect_chk u_lrect_chk (.*);

`default_nettype wire

[verif/layered_rect_overlap_index_core_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// layered_rect_overlap_index_core_test
// Self-checking bench for the layered rectangle overlap index: inserts,
// closed-overlap queries, clears and bad codes against an in-bench predictor,
// under random source gaps, sink stalls and several layer-limit settings.
// ============================================================================

module layered_rect_overlap_index_core_test;

    localparam int NLAYER = 8;
    localparam int DEPTH  = 32;

    // no package code for the spare func value; the block rejects it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;

    // Cycles with no word moving on any channel before we give up. The worst
    // legal quiet stretch is the forced sink hold-off plus a partial scan, the
    // longest sink stall and the longest source gap, so this is loose.
    localparam int QUIET_LIMIT = 3000;

    // ------------------------------------------------------------------------
    // Bucket predictor and result queue
    // ------------------------------------------------------------------------
    class overlap_board;
        lrect_pkg::box_t        store [NLAYER][DEPTH];
        logic [5:0]             fill [NLAYER];
        logic [5:0]             peak;
        int                     layers;
        lrect_pkg::out_item_t   due [$];
        int                     errors;

        function new();
            restart(4'd8);
            errors = 0;
        endfunction

        // layer-limit write: clamp, then empty every bucket
        function void restart(logic [3:0] v);
            layers = (v == 0) ? 1 : (v > NLAYER) ? NLAYER : int'(v);
            foreach (fill[i])
                fill[i] = '0;
            peak = '0;
        endfunction

        function void add(logic [2:0] kind, logic [4:0] slot, lrect_pkg::box_t b,
                          logic [5:0] cnt);
            lrect_pkg::out_item_t r;
            r.kind        = kind;
            r.found_slot  = slot;
            r.found_x_min = b.x_min;
            r.found_y_min = b.y_min;
            r.found_x_max = b.x_max;
            r.found_y_max = b.y_max;
            r.layer_count = cnt;
            r.peak_count  = peak;
            r.last        = 1'b0;
            due = {due, r};
        endfunction

        function void note_input(lrect_pkg::in_item_t w);
            lrect_pkg::box_t q;
            lrect_pkg::box_t f;
            lrect_pkg::box_t none;
            bit              ok;
            int              hits;
            int              cnt;
            q.x_min = w.box_x_min;
            q.y_min = w.box_y_min;
            q.x_max = w.box_x_max;
            q.y_max = w.box_y_max;
            none = '0;
            ok = w.layer < layers;
            hits = 0;
            case (w.func)
                lrect_pkg::FUNC_INSERT:
                begin
                    if (!ok)
                        add(lrect_pkg::KIND_REJECTED, 5'd0, none, 6'd0);
                    else if (fill[w.layer] >= DEPTH)
                        add(lrect_pkg::KIND_REJECTED, 5'd0, none, fill[w.layer]);
                    else
                    begin
                        store[w.layer][fill[w.layer]] = q;
                        fill[w.layer] = fill[w.layer] + 6'd1;
                        if (fill[w.layer] > peak)
                            peak = fill[w.layer];
                        add(lrect_pkg::KIND_INSERTED, 5'(fill[w.layer] - 6'd1), none,
                            fill[w.layer]);
                    end
                end
                lrect_pkg::FUNC_QUERY:
                begin
                    if (ok)
                    begin
                        cnt = int'(fill[w.layer]);
                        for (int i = 0; i < cnt && hits < lrect_pkg::RESULT_CAP; i++)
                        begin
                            f = store[w.layer][i];
                            // closed extents: touching edges still overlap
                            if (f.x_max < q.x_min || f.x_min > q.x_max)
                                continue;
                            if (f.y_max < q.y_min || f.y_min > q.y_max)
                                continue;
                            add(lrect_pkg::KIND_MATCH, 5'(i), f, 6'(cnt));
                            hits++;
                        end
                    end
                    if (hits == 0)
                        add(lrect_pkg::KIND_NO_MATCH, 5'd0, none,
                            ok ? fill[w.layer] : 6'd0);
                end
                lrect_pkg::FUNC_CLEAR:
                begin
                    foreach (fill[i])
                        fill[i] = '0;
                    peak = '0;
                    add(lrect_pkg::KIND_CLEARED, 5'd0, none, 6'd0);
                end
                default:
                    add(lrect_pkg::KIND_REJECTED, 5'd0, none, ok ? fill[w.layer] : 6'd0);
            endcase
            due[due.size() - 1].last = 1'b1;
        endfunction

        function void field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(lrect_pkg::out_item_t got);
            lrect_pkg::out_item_t want;
            if (due.size() == 0)
            begin
                $error("result word with nothing pending (kind %0d)", got.kind);
                errors++;
                return;
            end
            want = due.pop_front();
            field("kind",        32'(want.kind),        32'(got.kind));
            field("found_slot",  32'(want.found_slot),  32'(got.found_slot));
            field("found_x_min", want.found_x_min,      got.found_x_min);
            field("found_y_min", want.found_y_min,      got.found_y_min);
            field("found_x_max", want.found_x_max,      got.found_x_max);
            field("found_y_max", want.found_y_max,      got.found_y_max);
            field("layer_count", 32'(want.layer_count), 32'(got.layer_count));
            field("peak_count",  32'(want.peak_count),  32'(got.peak_count));
            field("last",        32'(want.last),        32'(got.last));
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    lrect_pkg::in_item_t             in_data;
    logic                            out_valid;
    logic                            out_stall;
    lrect_pkg::out_item_t            out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lrect_pkg::CFG_W-1:0]     cfg_data;

    overlap_board board = new();

    bit idle_on    = 1'b1;   // random gaps/stalls enabled
    int hold_burst = 0;      // forced sink hold-off, in cycles
    int quiet      = 0;

    layered_rect_overlap_index_core #(
        .MAX_LAYERS   (NLAYER),
        .BUCKET_DEPTH (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // ------------------------------------------------------------------------
    // Sink: handshakes are read right after the edge, which still shows the
    // pre-edge values because everything is driven nonblocking. Each result
    // draws its own stall; a forced hold-off overrides that.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                board.check_result(out_data);
                hold = idle_on ? $urandom_range(7) : 0;
            end
            if (hold_burst > 0)
            begin
                hold_burst--;
                out_stall <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: any word on any channel resets the quiet counter.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL layered_rect_overlap_index_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------

    // valid only drops when a gap is drawn, so a back-to-back word keeps it
    // high with a single assignment in that step
    task automatic send_word(input lrect_pkg::in_item_t w);
        int gap;
        gap = idle_on ? $urandom_range(7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // layer-limit write; block must be idle, so drain and let it settle first
    task automatic set_layers(input logic [3:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.restart(v);
    endtask

    function automatic lrect_pkg::in_item_t word(logic [1:0] func, logic [3:0] layer,
                                      logic signed [31:0] x0, logic signed [31:0] y0,
                                      logic signed [31:0] x1, logic signed [31:0] y1);
        lrect_pkg::in_item_t w;
        w.func      = func;
        w.layer     = layer;
        w.box_x_min = x0;
        w.box_y_min = y0;
        w.box_x_max = x1;
        w.box_y_max = y1;
        return w;
    endfunction

    // Mostly small well-formed boxes near the origin so queries hit many
    // stored boxes; a few inverted, full-range or random-edge boxes mixed in.
    function automatic lrect_pkg::in_item_t random_word(int ins_pct, bit allow_clear);
        lrect_pkg::in_item_t w;
        int                  r;
        int                  x0;
        int                  y0;
        logic signed [31:0]  t;
        r = $urandom_range(99);
        if (r < ins_pct)
            w.func = lrect_pkg::FUNC_INSERT;
        else if (r < 96)
            w.func = lrect_pkg::FUNC_QUERY;
        else if (r < 98)
            w.func = allow_clear ? lrect_pkg::FUNC_CLEAR : lrect_pkg::FUNC_QUERY;
        else
            w.func = FUNC_UNUSED;
        if ($urandom_range(9) == 0)
            w.layer = 4'($urandom_range(15));
        else
            w.layer = 4'($urandom_range(board.layers - 1));
        x0 = int'($urandom_range(60)) - 30;
        y0 = int'($urandom_range(60)) - 30;
        w.box_x_min = x0;
        w.box_y_min = y0;
        w.box_x_max = x0 + int'($urandom_range(12));
        w.box_y_max = y0 + int'($urandom_range(12));
        case ($urandom_range(19))
            0:
            begin
                t = w.box_x_min;
                w.box_x_min = w.box_x_max;
                w.box_x_max = t;
            end
            1:
            begin
                t = w.box_y_min;
                w.box_y_min = w.box_y_max;
                w.box_y_max = t;
            end
            2:
            begin
                w.box_x_min = $urandom;
                w.box_y_min = $urandom;
                w.box_x_max = $urandom;
                w.box_y_max = $urandom;
            end
            3:
            begin
                w.box_x_min = MIN32;
                w.box_x_max = MAX32;
            end
            default:
                ;
        endcase
        return w;
    endfunction

    task automatic run_random(input int n, input int ins_pct, input bit allow_clear);
        for (int k = 0; k < n; k++)
            send_word(random_word(ins_pct, allow_clear));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting of 8 layers
        send_word(word(lrect_pkg::FUNC_INSERT, 0, MIN32, MIN32, MAX32, MAX32)); // full range
        send_word(word(lrect_pkg::FUNC_INSERT, 0, 0, 0, 10, 10));
        send_word(word(lrect_pkg::FUNC_INSERT, 0, 10, 10, 0, 0));      // inverted, kept as is
        send_word(word(lrect_pkg::FUNC_INSERT, 7, -5, -5, -1, -1));    // top valid layer
        send_word(word(lrect_pkg::FUNC_INSERT, 15, 1, 1, 2, 2));       // layer out of range
        send_word(word(lrect_pkg::FUNC_INSERT, 8, 1, 1, 2, 2));        // first bad layer
        send_word(word(lrect_pkg::FUNC_QUERY, 0, 10, 10, 20, 20));     // corner touch counts
        send_word(word(lrect_pkg::FUNC_QUERY, 0, MIN32, MIN32, MIN32, MIN32));
        send_word(word(lrect_pkg::FUNC_QUERY, 0, MAX32, MAX32, MAX32, MAX32));
        send_word(word(lrect_pkg::FUNC_QUERY, 7, 0, 0, 5, 5));         // miss, nonempty layer
        send_word(word(lrect_pkg::FUNC_QUERY, 12, 0, 0, 5, 5));        // bad layer
        send_word(word(lrect_pkg::FUNC_QUERY, 3, MIN32, MIN32, MAX32, MAX32)); // empty layer
        send_word(word(lrect_pkg::FUNC_QUERY, 0, 20, 20, -20, -20));   // inverted query
        send_word(word(FUNC_UNUSED, 0, 0, 0, 0, 0));                   // spare code, good layer
        send_word(word(FUNC_UNUSED, 9, -1, -1, -1, -1));               // spare code, bad layer
        send_word(word(lrect_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0));
        send_word(word(lrect_pkg::FUNC_QUERY, 0, MIN32, MIN32, MAX32, MAX32)); // after clear
        send_word(word(lrect_pkg::FUNC_INSERT, 1, MAX32, MIN32, MAX32, MIN32));

        // zero clamps to one layer; heavy inserts fill layer 0 and hit full
        set_layers(4'd0);
        run_random(90, 70, 1'b0);

        // above the maximum clamps to 8
        set_layers(4'd15);
        run_random(110, 50, 1'b1);

        // mid setting, no idling on either side
        set_layers(4'($urandom_range(2, 7)));
        idle_on = 1'b0;
        run_random(80, 45, 1'b1);
        idle_on = 1'b1;

        // sink holds off for a long stretch while the source keeps offering
        set_layers(4'd8);
        hold_burst = 160;
        run_random(30, 60, 1'b0);
        run_random(60, 45, 1'b1);

        // single layer set directly
        set_layers(4'd1);
        run_random(40, 55, 1'b1);

        drain();
        repeat (40) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d expected result words never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("PASS layered_rect_overlap_index_core");
        else
            $display("FAIL layered_rect_overlap_index_core");
        $finish;
    end

endmodule
